@@ rtl/sme_pkg.sv @@
// Shared types and constants for the stable matching engine.
// Used by sme_ctrl, sme_datapath and stable_matching_engine_top; no dependencies.

package sme_pkg;

  // Largest number of couples the tables hold.
  localparam int MAX_COUPLES = 32;

  // Index of one person inside a table row.
  localparam int IDX_W = $clog2(MAX_COUPLES);

  // Field widths of the item and result ports.
  localparam int PERSON_W = 6;
  localparam int RANK_W   = 5;
  localparam int OP_W     = 2;

  // Counters that must also hold the couple count itself.
  localparam int CNT_W = IDX_W + 1;

  // One preference table holds MAX_COUPLES rows of MAX_COUPLES entries.
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_COUPLES * MAX_COUPLES;

  // Item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_PROPOSER = 2'd0,
    OP_LOAD_ACCEPTOR = 2'd1,
    OP_START         = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic pop;
    logic choose;
    logic pref;
    logic rank;
    logic emit;
  } sme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_empty;
    logic choice_ok;
    logic woman_bad;
    logic woman_free;
    logic emit_last;
  } sme_status_t;

endpackage

@@ rtl/sme_ctrl.sv @@
// Sequencing state machine for the stable matching engine.
// Depends on sme_pkg for the command and status structs and operation codes.

module sme_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sme_pkg::OP_W-1:0] operation,
  input  sme_pkg::sme_status_t     status,
  output sme_pkg::sme_cmd_t        cmd,
  output logic                     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_CHOOSE,
    S_PREF,
    S_RANK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow directly from state, start input and datapath status.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && (operation == sme_pkg::OP_START)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.pop = !status.q_empty;
        if (status.q_empty) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        cmd.choose = status.choice_ok;
        if (status.choice_ok) begin
          state_next = S_PREF;
        end else begin
          state_next = S_POP;
        end
      end
      S_PREF: begin
        cmd.pref = 1'b1;
        if (status.woman_bad || status.woman_free) begin
          state_next = S_POP;
        end else begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        cmd.rank   = 1'b1;
        state_next = S_POP;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  // Only one datapath command is active in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("More than one datapath command at once.");

  // A start item taken while idle always begins a run.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && operation == sme_pkg::OP_START) |=> (state == S_INIT && busy))
    else $error("Start item did not begin a run.");

  // Busy is low exactly when the machine rests in idle.
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("Busy flag disagrees with the state.");

endmodule

@@ rtl/sme_datapath.sv @@
// Tables, free-proposer queue, working arrays and result registers of the engine.
// Depends on sme_pkg; driven by sme_ctrl commands and the item and config ports.

module sme_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  sme_pkg::sme_cmd_t            cmd,
  output sme_pkg::sme_status_t         status,
  input  logic [sme_pkg::OP_W-1:0]     operation,
  input  logic [sme_pkg::PERSON_W-1:0] person,
  input  logic [sme_pkg::RANK_W-1:0]   rank,
  input  logic [sme_pkg::PERSON_W-1:0] partner,
  input  logic                         cfg_wr_en,
  input  logic [sme_pkg::PERSON_W-1:0] cfg_wr_data,
  output logic                         done,
  output logic [sme_pkg::PERSON_W-1:0] acceptor,
  output logic [sme_pkg::PERSON_W-1:0] matched_proposer,
  output logic                         last
);

  localparam int IDX_W    = sme_pkg::IDX_W;
  localparam int CNT_W    = sme_pkg::CNT_W;
  localparam int PERSON_W = sme_pkg::PERSON_W;
  localparam int RANK_W   = sme_pkg::RANK_W;
  localparam int ADDR_W   = sme_pkg::ADDR_W;
  localparam int MAXC     = sme_pkg::MAX_COUPLES;

  // Preference tables, never cleared.
  logic [PERSON_W-1:0] pref_mem [sme_pkg::MEM_DEPTH];
  logic [RANK_W-1:0]   rank_mem [sme_pkg::MEM_DEPTH];
  logic [PERSON_W-1:0] pref_rdata;
  logic [RANK_W-1:0]   rank_new_rdata;
  logic [RANK_W-1:0]   rank_cur_rdata;

  // Working state of one run.
  logic [CNT_W-1:0]    next_choice [MAXC];
  logic [PERSON_W-1:0] engaged     [MAXC];
  logic [PERSON_W-1:0] free_queue  [MAXC];
  logic [IDX_W-1:0]    q_head;
  logic [CNT_W-1:0]    q_count;
  logic [CNT_W-1:0]    n_r;
  logic [PERSON_W-1:0] couple_count;
  logic [PERSON_W-1:0] man_r;
  logic [PERSON_W-1:0] cur_r;
  logic [IDX_W-1:0]    woman_idx_r;
  logic [IDX_W-1:0]    emit_idx;

  logic [CNT_W-1:0]    n_clamped;
  logic [PERSON_W-1:0] person_m1;
  logic [PERSON_W-1:0] partner_m1;
  logic [PERSON_W-1:0] man_m1;
  logic [PERSON_W-1:0] woman_m1;
  logic [PERSON_W-1:0] cur_m1;
  logic [IDX_W-1:0]    man_idx;
  logic [IDX_W-1:0]    woman_idx;
  logic [CNT_W-1:0]    choice;
  logic [PERSON_W-1:0] engaged_w;
  logic                person_ok;
  logic                rank_ok;
  logic                partner_ok;
  logic                pref_we;
  logic                rank_we;
  logic                better;
  logic                push_en;
  logic [PERSON_W-1:0] push_val;
  logic [CNT_W:0]      tail_sum;
  logic [IDX_W-1:0]    tail;
  logic [IDX_W-1:0]    head_inc;
  logic [CNT_W-1:0]    emit_num;

  // Couple count as used: zero acts as one, large values saturate.
  always_comb begin
    if (couple_count == '0) begin
      n_clamped = CNT_W'(1);
    end else if (couple_count > PERSON_W'(MAXC)) begin
      n_clamped = CNT_W'(MAXC);
    end else begin
      n_clamped = CNT_W'(couple_count);
    end
  end

  // Load item decode; out-of-range loads are dropped.
  assign person_m1  = person - PERSON_W'(1);
  assign partner_m1 = partner - PERSON_W'(1);
  assign person_ok  = (person != '0) && (person <= PERSON_W'(MAXC));
  assign rank_ok    = ({1'b0, rank} < (RANK_W + 1)'(MAXC));
  assign partner_ok = (partner != '0) && (partner <= PERSON_W'(MAXC));
  assign pref_we    = cmd.load && (operation == sme_pkg::OP_LOAD_PROPOSER)
                      && person_ok && rank_ok;
  assign rank_we    = cmd.load && (operation == sme_pkg::OP_LOAD_ACCEPTOR)
                      && person_ok && rank_ok && partner_ok;

  // Indexes of the current proposer, the proposed-to acceptor and her partner.
  assign man_m1    = man_r - PERSON_W'(1);
  assign man_idx   = man_m1[IDX_W-1:0];
  assign choice    = next_choice[man_idx];
  assign woman_m1  = pref_rdata - PERSON_W'(1);
  assign woman_idx = woman_m1[IDX_W-1:0];
  assign engaged_w = engaged[woman_idx];
  assign cur_m1    = engaged_w - PERSON_W'(1);
  assign better    = (rank_new_rdata < rank_cur_rdata);

  // Status for the controller.
  assign emit_num          = CNT_W'(emit_idx) + CNT_W'(1);
  assign status.q_empty    = (q_count == '0);
  assign status.choice_ok  = (choice < n_r);
  assign status.woman_bad  = (pref_rdata == '0) || (CNT_W'(pref_rdata) > n_r);
  assign status.woman_free = (engaged_w == '0);
  assign status.emit_last  = (emit_num == n_r);

  // Queue push: a rejected or displaced proposer goes to the tail.
  always_comb begin
    push_en  = 1'b0;
    push_val = man_r;
    if (cmd.pref && status.woman_bad) begin
      push_en = 1'b1;
    end else if (cmd.rank) begin
      push_en = 1'b1;
      if (better) begin
        push_val = cur_r;
      end
    end
  end

  // Ring index arithmetic for the queue.
  assign tail_sum = (CNT_W + 1)'(q_head) + (CNT_W + 1)'(q_count);
  assign tail     = (tail_sum >= (CNT_W + 1)'(MAXC)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(MAXC)) : IDX_W'(tail_sum);
  assign head_inc = (q_head == IDX_W'(MAXC - 1)) ? '0 : q_head + IDX_W'(1);

  // Preference tables: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (pref_we) begin
      pref_mem[{person_m1[IDX_W-1:0], rank[IDX_W-1:0]}] <= partner;
    end
    if (cmd.choose) begin
      pref_rdata <= pref_mem[{man_idx, choice[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[{person_m1[IDX_W-1:0], partner_m1[IDX_W-1:0]}] <= rank;
    end
    if (cmd.pref) begin
      rank_new_rdata <= rank_mem[ADDR_W'({woman_idx, man_idx})];
      rank_cur_rdata <= rank_mem[ADDR_W'({woman_idx, cur_m1[IDX_W-1:0]})];
    end
  end

  // Control registers: configuration, queue pointers, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      couple_count <= PERSON_W'(MAXC);
      q_head       <= '0;
      q_count      <= '0;
      n_r          <= CNT_W'(MAXC);
      emit_idx     <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        couple_count <= cfg_wr_data;
      end
      done <= cmd.emit;
      if (cmd.init) begin
        q_head   <= '0;
        q_count  <= n_clamped;
        n_r      <= n_clamped;
        emit_idx <= '0;
      end else if (cmd.pop) begin
        q_head  <= head_inc;
        q_count <= q_count - CNT_W'(1);
      end else if (push_en) begin
        q_count <= q_count + CNT_W'(1);
      end
      if (cmd.emit) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
    end
  end

  // Working arrays and result payload.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MAXC; i++) begin
        next_choice[i] <= '0;
        engaged[i]     <= '0;
        free_queue[i]  <= PERSON_W'(i + 1);
      end
    end else begin
      if (cmd.pop) begin
        man_r <= free_queue[q_head];
      end
      if (cmd.choose) begin
        next_choice[man_idx] <= choice + CNT_W'(1);
      end
      if (cmd.pref) begin
        woman_idx_r <= woman_idx;
        cur_r       <= engaged_w;
        if (!status.woman_bad && status.woman_free) begin
          engaged[woman_idx] <= man_r;
        end
      end
      if (cmd.rank && better) begin
        engaged[woman_idx_r] <= man_r;
      end
      if (push_en) begin
        free_queue[tail] <= push_val;
      end
    end
    if (cmd.emit) begin
      acceptor         <= PERSON_W'(emit_num);
      matched_proposer <= engaged[emit_idx];
      last             <= status.emit_last;
    end
  end

  // The queue never holds more proposers than take part in the run.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= n_r)
    else $error("Free queue holds more proposers than the couple count.");

  // A pop is only issued on a non-empty queue, and never with a push.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (q_count != '0) && !push_en)
    else $error("Pop from an empty queue or together with a push.");

  // A run starts with every proposer free.
  a_init_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.init |=> (q_count == n_r) && (q_head == '0))
    else $error("Queue not filled at the start of a run.");

  // The final result of a run is not followed by another.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (done && last) |=> !done)
    else $error("Result strobe continued after the final result.");

endmodule

@@ rtl/stable_matching_engine_top.sv @@
// A load item is accepted every cycle while busy is low. A start item runs a setup state,
// then pop, choose and pref states per proposal, plus rank when the acceptor is in range and
// engaged; a proposer whose list is used up passes pop and choose only; a last pop finds
// the queue empty. Emit states give the acceptors in order, each result strobe registered.
// busy falls in the cycle that carries the final result. Results cannot be stalled.
// Synchronous active-high reset clears control and sets couple_count to 32; tables are kept.

module stable_matching_engine_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sme_pkg::OP_W-1:0]     operation,
  input  logic [sme_pkg::PERSON_W-1:0] person,
  input  logic [sme_pkg::RANK_W-1:0]   rank,
  input  logic [sme_pkg::PERSON_W-1:0] partner,
  input  logic                         cfg_wr_en,
  input  logic [sme_pkg::PERSON_W-1:0] cfg_wr_data,
  output logic                         done,
  output logic [sme_pkg::PERSON_W-1:0] acceptor,
  output logic [sme_pkg::PERSON_W-1:0] matched_proposer,
  output logic                         last
);

  sme_pkg::sme_cmd_t    cmd;
  sme_pkg::sme_status_t status;

  // Proposal sequencer.
  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Tables, queue and result registers.
  sme_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .operation        (operation),
    .person           (person),
    .rank             (rank),
    .partner          (partner),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .done             (done),
    .acceptor         (acceptor),
    .matched_proposer (matched_proposer),
    .last             (last)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stable_matching_engine_top (Gale-Shapley matching).
// Depends on sme_pkg and the engine RTL; the expected matchings come from a predictor kept here.

module tb;

  localparam int MAX_COUPLES = sme_pkg::MAX_COUPLES;
  localparam int OP_W = sme_pkg::OP_W;
  localparam int PERSON_W = sme_pkg::PERSON_W;
  localparam int RANK_W = sme_pkg::RANK_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 120;
  localparam int FULL_N = 6;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One acceptor line of a finished matching.
  typedef struct {
    int acceptor;
    int proposer;
    bit last;
  } match_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [OP_W-1:0] operation;
  logic [PERSON_W-1:0] person;
  logic [RANK_W-1:0] rank;
  logic [PERSON_W-1:0] partner;
  logic cfg_wr_en;
  logic [PERSON_W-1:0] cfg_wr_data;
  logic done;
  logic [PERSON_W-1:0] acceptor;
  logic [PERSON_W-1:0] matched_proposer;
  logic last;

  // Predictor state: the two preference stores and the couple count register.
  logic [PERSON_W-1:0] pref_of [1:MAX_COUPLES][0:MAX_COUPLES-1];
  logic [RANK_W-1:0] rank_given [1:MAX_COUPLES][1:MAX_COUPLES];
  logic [PERSON_W-1:0] couple_cfg;
  match_t expected_matches[$];
  match_t want;

  int error_count;
  int cycle_count;
  int items_sent;
  int runs_started;
  int results_checked;
  int random_items;
  bit burst_mode;

  stable_matching_engine_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .person           (person),
    .rank             (rank),
    .partner          (partner),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .done             (done),
    .acceptor         (acceptor),
    .matched_proposer (matched_proposer),
    .last             (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung engine or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("MISMATCH cycle %0d: %s expected %0d got %0d", cycle_count, what, exp_val, got_val);
    error_count++;
  endtask

  // Runs proposer-optimal Gale-Shapley on the predicted stores and queues the results.
  function automatic void predict_matching();
    int n;
    int next_pick [1:MAX_COUPLES];
    int engaged [1:MAX_COUPLES];
    int free_q[$];
    int man;
    int choice;
    int woman;
    int cur;
    match_t m;
    n = (couple_cfg == 0) ? 1 : ((couple_cfg > MAX_COUPLES) ? MAX_COUPLES : int'(couple_cfg));
    for (int i = 1; i <= MAX_COUPLES; i++) begin
      next_pick[i] = 0;
      engaged[i] = 0;
    end
    for (int i = 1; i <= n; i++) free_q = {free_q, i};
    while (free_q.size() > 0) begin
      man = free_q.pop_front();
      choice = next_pick[man];
      // A proposer who has tried every choice drops out unmatched.
      if (choice >= n) continue;
      woman = pref_of[man][choice];
      next_pick[man] = choice + 1;
      // A target outside the active range counts as a rejection.
      if (woman == 0 || woman > n) begin
        free_q = {free_q, man};
        continue;
      end
      if (engaged[woman] == 0) begin
        engaged[woman] = man;
      end else begin
        cur = engaged[woman];
        // She trades up only on a strictly better rank; ties keep the current partner.
        if (rank_given[woman][man] < rank_given[woman][cur]) begin
          engaged[woman] = man;
          free_q = {free_q, cur};
        end else begin
          free_q = {free_q, man};
        end
      end
    end
    for (int a = 1; a <= n; a++) begin
      m.acceptor = a;
      m.proposer = engaged[a];
      m.last = (a == n);
      expected_matches = {expected_matches, m};
    end
  endfunction

  // Applies one accepted item to the predictor.
  function automatic void record_item(input logic [OP_W-1:0] op, input int who, input int pos,
                                      input int other);
    bit who_ok;
    who_ok = (who >= 1) && (who <= MAX_COUPLES) && (pos < MAX_COUPLES);
    case (op)
      sme_pkg::OP_LOAD_PROPOSER: begin
        if (who_ok) pref_of[who][pos] = other[PERSON_W-1:0];
      end
      sme_pkg::OP_LOAD_ACCEPTOR: begin
        if (who_ok && other >= 1 && other <= MAX_COUPLES) rank_given[who][other] = pos[RANK_W-1:0];
      end
      sme_pkg::OP_START: begin
        predict_matching();
        runs_started++;
      end
      default: ;
    endcase
  endfunction

  // Sends one item after a random gap and waits until the engine takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input int who, input int pos,
                           input int other);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    person <= who[PERSON_W-1:0];
    rank <= pos[RANK_W-1:0];
    partner <= other[PERSON_W-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    record_item(op, who, pos, other);
    items_sent++;
    @(negedge clk);
  endtask

  // Writes the couple count once the engine has drained and gone idle.
  task automatic write_couple_count(input int value);
    start <= 1'b0;
    wait (expected_matches.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[PERSON_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    couple_cfg = value[PERSON_W-1:0];
  endtask

  // Fills a random permutation of 1..k.
  function automatic void shuffle_people(input int k, output int perm[$]);
    int j;
    int t;
    perm = {};
    for (int i = 1; i <= k; i++) perm = {perm, i};
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endfunction

  task automatic load_proposer_row(input int who, input int k);
    int perm[$];
    shuffle_people(k, perm);
    for (int r = 0; r < k; r++) send_item(sme_pkg::OP_LOAD_PROPOSER, who, r, perm[r]);
  endtask

  // With tied set, ranks are random so that equal ranks show up.
  task automatic load_acceptor_row(input int who, input int k, input bit tied);
    int perm[$];
    shuffle_people(k, perm);
    for (int r = 0; r < k; r++)
      send_item(sme_pkg::OP_LOAD_ACCEPTOR, who, tied ? $urandom_range(0, MAX_COUPLES - 1) : r,
                perm[r]);
  endtask

  // Every entry of both stores within the first FULL_N couples gets written, then a run.
  task automatic test_full_tables();
    burst_mode = 1'b0;
    write_couple_count(FULL_N);
    for (int p = 1; p <= FULL_N; p++) load_proposer_row(p, FULL_N);
    for (int a = 1; a <= FULL_N; a++) load_acceptor_row(a, FULL_N, 1'b0);
    send_item(sme_pkg::OP_START, FULL_N, FULL_N - 1, FULL_N);
  endtask

  // Two couples where acceptor 1 ranks both proposers equally and keeps the first.
  task automatic test_tie();
    write_couple_count(2);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 1, 0, 1);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 1, 1, 2);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 2, 0, 1);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 2, 1, 2);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 1, 0, 1);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 1, 0, 2);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 2, 0, 1);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 2, 1, 2);
    send_item(sme_pkg::OP_START, 0, 0, 0);
  endtask

  // Out-of-range loads and the unused operation must leave the stores alone;
  // proposer entries of 0 and 63 become targets that are always rejected.
  task automatic test_ignored_and_bad_targets();
    write_couple_count(3);
    send_item(OP_UNUSED, 63, 31, 63);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 0, 0, 1);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 40, 31, 2);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 1, 0, 0);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 2, 0, 63);
    send_item(sme_pkg::OP_LOAD_ACCEPTOR, 63, 0, 1);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 1, 0, 0);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 2, 0, 63);
    send_item(sme_pkg::OP_LOAD_PROPOSER, 32, 31, 1);
    send_item(sme_pkg::OP_START, 1, 1, 1);
  endtask

  // Couple counts of 0 and above the table size are clamped by the engine. Each proposer
  // first picks the acceptor with the same number, so every first proposal is accepted.
  task automatic test_count_extremes();
    int settings[4] = '{0, 63, 33, 1};
    for (int p = 1; p <= MAX_COUPLES; p++) send_item(sme_pkg::OP_LOAD_PROPOSER, p, 0, p);
    foreach (settings[i]) begin
      write_couple_count(settings[i]);
      send_item(sme_pkg::OP_START, 0, 0, 0);
    end
  endtask

  // Random phases: new couple count, rewritten lists with some noise, then a run.
  task automatic test_random_phases();
    int sel;
    int cfg;
    int n;
    int rows;
    int noise;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 7);
      cfg = (sel == 0) ? 0 : $urandom_range(1, FULL_N);
      n = (cfg == 0) ? 1 : cfg;
      write_couple_count(cfg);
      burst_mode = ($urandom_range(0, 3) == 0);
      rows = $urandom_range(1, (n < 4) ? n : 4);
      for (int i = 0; i < rows; i++) begin
        load_proposer_row($urandom_range(1, n), n);
        load_acceptor_row($urandom_range(1, n), n, $urandom_range(0, 3) == 0);
        random_items += 2 * n;
      end
      noise = $urandom_range(0, 3);
      for (int i = 0; i < noise; i++)
        send_item(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 31),
                  $urandom_range(0, 63));
      random_items += noise;
      send_item(sme_pkg::OP_START, $urandom_range(0, 63), $urandom_range(0, 31),
                $urandom_range(0, 63));
      random_items++;
    end
  endtask

  // Compares each result strobe with the oldest predicted acceptor line.
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("unexpected result for acceptor", 0, acceptor);
      end else begin
        want = expected_matches.pop_front();
        if (acceptor !== want.acceptor)
          report_mismatch("acceptor", want.acceptor, acceptor);
        if (matched_proposer !== want.proposer)
          report_mismatch($sformatf("proposer of acceptor %0d", want.acceptor), want.proposer,
                          matched_proposer);
        if (last !== want.last)
          report_mismatch($sformatf("last flag of acceptor %0d", want.acceptor), want.last, last);
        results_checked++;
      end
    end
  end

  initial begin
    error_count = 0;
    items_sent = 0;
    runs_started = 0;
    results_checked = 0;
    burst_mode = 1'b0;
    couple_cfg = MAX_COUPLES;
    rst = 1'b1;
    start = 1'b0;
    operation = sme_pkg::OP_LOAD_PROPOSER;
    person = '0;
    rank = '0;
    partner = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_full_tables();
    test_tie();
    test_ignored_and_bad_targets();
    test_count_extremes();
    test_random_phases();

    // Drain the last run before the verdict.
    start <= 1'b0;
    wait (expected_matches.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d items with %0d matching runs and checked %0d acceptor results,",
             items_sent, runs_started, results_checked);
    $display("covering ties, dropped loads, rejected targets, clamped counts and random lists.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sme_pkg.sv
rtl/sme_ctrl.sv
rtl/sme_datapath.sv
rtl/stable_matching_engine_top.sv
verif/tb.sv
